// ===== hdl/aqi_pkg.sv =====
// Shared types, codes and helper functions of the attitude quaternion integrator.
package aqi_pkg;

    localparam int QUAT_WIDTH_DEF = 32;
    localparam int RATE_WIDTH_DEF = 32;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_TIME      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_X      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_Y      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_Z      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_SCALAR = 3'd4;

    localparam logic [31:0] STEP_TIME_RESET = 32'd16777216;
    localparam logic [31:0] ONE_Q30         = 32'd1073741824;

    localparam int MOPW  = 34;   // multiplier operand width
    localparam int PRODW = 68;   // multiplier product width
    localparam int ACCW  = 65;   // sum of three rate products
    localparam int WIDEW = 98;   // sum times step time
    localparam int UW    = 50;   // unnormalised part
    localparam int MW    = 49;   // magnitude of an unnormalised part
    localparam int CNTW  = 6;

    localparam int INC_LAST   = 7;
    localparam int SQ_LAST    = 4;
    localparam int DIV_STEPS  = 62;
    localparam int SQRT_STEPS = 32;
    localparam int INC_SHIFT  = 49;

    typedef logic [3:0] op_t;
    localparam op_t OP_NONE    = 4'd0;
    localparam op_t OP_CAPTURE = 4'd1;
    localparam op_t OP_INC     = 4'd2;
    localparam op_t OP_MAG     = 4'd3;
    localparam op_t OP_SCALE   = 4'd4;
    localparam op_t OP_SQ      = 4'd5;
    localparam op_t OP_DSQ     = 4'd6;
    localparam op_t OP_DINIT   = 4'd7;
    localparam op_t OP_DIV     = 4'd8;
    localparam op_t OP_SQRT    = 4'd9;
    localparam op_t OP_RES     = 4'd10;
    localparam op_t OP_COMMIT  = 4'd11;

    typedef struct packed {
        op_t        op;
        logic [1:0] part;
        logic [2:0] step;
    } aqi_cmd_t;

    typedef struct packed {
        logic is_load;
        logic fits;
        logic s_zero;
    } aqi_status_t;

    // Quaternion part used by term k of the rate product for output part p.
    // Parts: 0 x, 1 y, 2 z, 3 scalar.
    function automatic logic [1:0] term_qidx(input logic [1:0] p, input logic [1:0] k);
        logic [1:0] r;
        case ({p, k})
            4'b00_00: r = 2'd3;
            4'b00_01: r = 2'd2;
            4'b00_10: r = 2'd1;
            4'b01_00: r = 2'd2;
            4'b01_01: r = 2'd3;
            4'b01_10: r = 2'd0;
            4'b10_00: r = 2'd1;
            4'b10_01: r = 2'd0;
            4'b10_10: r = 2'd3;
            4'b11_00: r = 2'd0;
            4'b11_01: r = 2'd1;
            4'b11_10: r = 2'd2;
            default:  r = 2'd0;
        endcase
        return r;
    endfunction

    function automatic logic term_neg(input logic [1:0] p, input logic [1:0] k);
        logic r;
        case ({p, k})
            4'b00_01: r = 1'b1;
            4'b01_10: r = 1'b1;
            4'b10_00: r = 1'b1;
            4'b11_00: r = 1'b1;
            4'b11_01: r = 1'b1;
            4'b11_10: r = 1'b1;
            default:  r = 1'b0;
        endcase
        return r;
    endfunction

    // Saturate a sign-extended value to the 32 bit range.
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647)
            r = 32'sh7FFF_FFFF;
        else if (v < -64'sd2147483648)
            r = 32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

// ===== hdl/attitude_quaternion_integrator_core.sv =====
// Top level of the attitude quaternion integrator: sequencer plus datapath.
//
// Usage: the block keeps an attitude quaternion (x, y, z, scalar) in Q2.30.
// Input channel (in_valid/in_stall) carries one word: command plus three body
// rates in Q8.24 rad/s. Command 0 propagates one Euler step of quaternion
// kinematics using step_time, then renormalises (scalar part kept positive);
// command 1 copies the initial-attitude registers into the state.
// Output channel (out_valid/out_stall) returns one word per input word: the
// new attitude and the degenerate flag (zero norm, state held).
// A load word goes from dispatch straight to commit. A propagate word is
// dispatched, forms its increment through the one shared 34x34 multiplier,
// is block scaled, forms the sum of squares and a zero check (zero norm: on
// to commit), runs a bit-serial 62-step division and a 32-step square root
// per part, and commits; a next word can be taken the cycle after commit.
// One word is in flight at a time; in_stall is high from acceptance until the
// result has been placed in the output register.
// A finished word waits in the output register while out_stall is high; the
// next input word is still taken, and its result waits until the slot frees.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once and
// belong in idle periods only.
// Reset: step_time 1.0 s, initial attitude and state the identity quaternion,
// no word pending.
module attitude_quaternion_integrator_core
    import aqi_pkg::*;
#(
    parameter int QUAT_WIDTH = QUAT_WIDTH_DEF,
    parameter int RATE_WIDTH = RATE_WIDTH_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [((QUAT_WIDTH > 32) ? QUAT_WIDTH : 32)-1:0] cfg_data,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         command,
    input  logic signed [RATE_WIDTH-1:0] rate_x,
    input  logic signed [RATE_WIDTH-1:0] rate_y,
    input  logic signed [RATE_WIDTH-1:0] rate_z,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [QUAT_WIDTH-1:0] att_x,
    output logic signed [QUAT_WIDTH-1:0] att_y,
    output logic signed [QUAT_WIDTH-1:0] att_z,
    output logic signed [QUAT_WIDTH-1:0] att_scalar,
    output logic                         degenerate
);

    // Config data is as wide as the widest register.
    localparam int CFG_W = (QUAT_WIDTH > 32) ? QUAT_WIDTH : 32;

    aqi_cmd_t    cmd;
    aqi_status_t st;

    // Sequencer: handshakes, step counters, output slot.
    aqi_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .st        (st)
    );

    // Datapath: config registers, state, arithmetic and result word.
    aqi_dp #(
        .QUAT_WIDTH (QUAT_WIDTH),
        .RATE_WIDTH (RATE_WIDTH),
        .CFG_W      (CFG_W)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .command    (command),
        .rate_x     (rate_x),
        .rate_y     (rate_y),
        .rate_z     (rate_z),
        .cmd        (cmd),
        .st         (st),
        .att_x      (att_x),
        .att_y      (att_y),
        .att_z      (att_z),
        .att_scalar (att_scalar),
        .degenerate (degenerate)
    );

    // Hold off further words once one has been taken.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input accepted while a word is still in flight");

    // Never overwrite a result the receiver has not yet taken.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_COMMIT) |-> (!out_valid || !out_stall))
        else $error("result register overwritten while stalled");

    // A new result only appears while the block is still busy with its word.
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result produced without a word in flight");

endmodule

// ===== hdl/aqi_ctrl.sv =====
// Sequencer of the attitude quaternion integrator: handshakes and step control.
module aqi_ctrl
    import aqi_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    output logic        out_valid,
    input  logic        out_stall,
    output aqi_cmd_t    cmd,
    input  aqi_status_t st
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DISP  = 4'd1;
    localparam logic [3:0] S_INC   = 4'd2;
    localparam logic [3:0] S_MAG   = 4'd3;
    localparam logic [3:0] S_SCALE = 4'd4;
    localparam logic [3:0] S_SQ    = 4'd5;
    localparam logic [3:0] S_ZCHK  = 4'd6;
    localparam logic [3:0] S_DSQ   = 4'd7;
    localparam logic [3:0] S_DINIT = 4'd8;
    localparam logic [3:0] S_DIV   = 4'd9;
    localparam logic [3:0] S_SQRT  = 4'd10;
    localparam logic [3:0] S_RES   = 4'd11;
    localparam logic [3:0] S_FIN   = 4'd12;

    logic [3:0]      state_reg, state_next;
    logic [1:0]      part_reg, part_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic            out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        part_next  = part_reg;
        cnt_next   = cnt_reg;
        cmd.op     = OP_NONE;
        cmd.part   = part_reg;
        cmd.step   = cnt_reg[2:0];
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_CAPTURE;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                part_next = 2'd0;
                cnt_next  = '0;
                state_next = st.is_load ? S_FIN : S_INC;
            end
            S_INC:
            begin
                cmd.op = OP_INC;
                if (cnt_reg == CNTW'(INC_LAST))
                begin
                    cnt_next = '0;
                    if (part_reg == 2'd3)
                        state_next = S_MAG;
                    else
                        part_next = part_reg + 2'd1;
                end
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            S_MAG:
            begin
                cmd.op     = OP_MAG;
                state_next = S_SCALE;
            end
            S_SCALE:
            begin
                if (st.fits)
                begin
                    cnt_next   = '0;
                    state_next = S_SQ;
                end
                else
                    cmd.op = OP_SCALE;
            end
            S_SQ:
            begin
                cmd.op = OP_SQ;
                if (cnt_reg == CNTW'(SQ_LAST))
                    state_next = S_ZCHK;
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            S_ZCHK:
            begin
                part_next  = 2'd0;
                state_next = st.s_zero ? S_FIN : S_DSQ;
            end
            S_DSQ:
            begin
                cmd.op     = OP_DSQ;
                state_next = S_DINIT;
            end
            S_DINIT:
            begin
                cmd.op     = OP_DINIT;
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.op = OP_DIV;
                if (cnt_reg == CNTW'(DIV_STEPS - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_SQRT;
                end
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            S_SQRT:
            begin
                cmd.op = OP_SQRT;
                if (cnt_reg == CNTW'(SQRT_STEPS - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_RES;
                end
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            S_RES:
            begin
                cmd.op = OP_RES;
                if (part_reg == 2'd3)
                    state_next = S_FIN;
                else
                begin
                    part_next  = part_reg + 2'd1;
                    state_next = S_DSQ;
                end
            end
            S_FIN:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.op     = OP_COMMIT;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.op == OP_COMMIT)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            part_reg      <= 2'd0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            part_reg      <= part_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ===== hdl/aqi_dp.sv =====
// Datapath of the attitude quaternion integrator: registers, multiplier, divider and root.
module aqi_dp
    import aqi_pkg::*;
#(
    parameter int QUAT_WIDTH = QUAT_WIDTH_DEF,
    parameter int RATE_WIDTH = RATE_WIDTH_DEF,
    parameter int CFG_W      = 32
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_W-1:0]             cfg_data,
    input  logic                         command,
    input  logic signed [RATE_WIDTH-1:0] rate_x,
    input  logic signed [RATE_WIDTH-1:0] rate_y,
    input  logic signed [RATE_WIDTH-1:0] rate_z,
    input  aqi_cmd_t                     cmd,
    output aqi_status_t                  st,
    output logic signed [QUAT_WIDTH-1:0] att_x,
    output logic signed [QUAT_WIDTH-1:0] att_y,
    output logic signed [QUAT_WIDTH-1:0] att_z,
    output logic signed [QUAT_WIDTH-1:0] att_scalar,
    output logic                         degenerate
);

    logic [31:0]              dt_reg;
    logic signed [31:0]       init_reg [4];
    logic signed [31:0]       att_reg  [4];
    logic                     load_reg;
    logic signed [31:0]       w_reg    [3];
    logic signed [PRODW-1:0]  prod_reg;
    logic signed [ACCW-1:0]   acc_reg;
    logic signed [WIDEW-1:0]  wide_reg;
    logic signed [UW-1:0]     u_reg    [4];
    logic [MW-1:0]            mag_reg  [4];
    logic [3:0]               uneg_reg;
    logic                     flip_reg;
    logic [63:0]              s_reg;
    logic [63:0]              rem_reg;
    logic [63:0]              quo_reg;
    logic [31:0]              root_reg;
    logic [35:0]              srem_reg;
    logic signed [31:0]       res_reg  [4];
    logic signed [31:0]       out_reg  [4];
    logic                     degen_reg;

    logic signed [MOPW-1:0]   mul_a, mul_b;
    logic signed [PRODW-1:0]  prod_full;
    logic signed [31:0]       cfg_quat;
    logic signed [31:0]       att_new  [4];
    logic [1:0]               term;
    logic signed [ACCW-1:0]   pv;
    logic signed [UW-1:0]     incv;
    logic [64:0]              r2;
    logic                     div_ge;
    logic [35:0]              rem2, trial;
    logic                     sq_ge;
    logic [32:0]              cp;
    logic signed [31:0]       cval;
    logic [63:0]              a2;

    assign cfg_quat = sat32(64'($signed(cfg_data[QUAT_WIDTH-1:0])));

    // Operand selection for the one shared multiplier.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_INC:
            begin
                if (cmd.step <= 3'd2)
                begin
                    mul_a = MOPW'(att_reg[term_qidx(cmd.part, cmd.step[1:0])]);
                    mul_b = MOPW'(w_reg[cmd.step[1:0]]);
                end
                else if (cmd.step == 3'd4)
                begin
                    mul_a = MOPW'($signed(acc_reg[ACCW-1:32]));
                    mul_b = $signed({2'b00, dt_reg});
                end
                else if (cmd.step == 3'd5)
                begin
                    mul_a = $signed({2'b00, acc_reg[31:0]});
                    mul_b = $signed({2'b00, dt_reg});
                end
            end
            OP_SQ:
            begin
                mul_a = $signed({3'b000, mag_reg[cmd.step[1:0]][30:0]});
                mul_b = mul_a;
            end
            OP_DSQ:
            begin
                mul_a = $signed({3'b000, mag_reg[cmd.part][30:0]});
                mul_b = mul_a;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_full = PRODW'(mul_a) * PRODW'(mul_b);

    assign term = 2'(cmd.step - 3'd1);
    assign pv   = term_neg(cmd.part, term) ? -ACCW'(prod_reg) : ACCW'(prod_reg);
    assign incv = UW'(wide_reg >>> INC_SHIFT);

    assign r2     = {rem_reg, 1'b0};
    assign div_ge = (r2 >= {1'b0, s_reg});
    assign rem2   = {srem_reg[33:0], quo_reg[63:62]};
    assign trial  = {2'b00, root_reg, 2'b01};
    assign sq_ge  = (rem2 >= trial);
    assign cp     = {1'b0, root_reg} + 33'd1;
    assign cval   = $signed(cp[32:1]);
    assign a2     = prod_reg[63:0];

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            if (load_reg)
                att_new[i] = init_reg[i];
            else if (st.s_zero)
                att_new[i] = att_reg[i];
            else
                att_new[i] = res_reg[i];
        end
    end

    // Configuration registers and attitude state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dt_reg      <= STEP_TIME_RESET;
            init_reg[0] <= '0;
            init_reg[1] <= '0;
            init_reg[2] <= '0;
            init_reg[3] <= $signed(ONE_Q30);
            att_reg[0]  <= '0;
            att_reg[1]  <= '0;
            att_reg[2]  <= '0;
            att_reg[3]  <= $signed(ONE_Q30);
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_STEP_TIME:      dt_reg      <= cfg_data[31:0];
                    REG_INITIAL_X:      init_reg[0] <= cfg_quat;
                    REG_INITIAL_Y:      init_reg[1] <= cfg_quat;
                    REG_INITIAL_Z:      init_reg[2] <= cfg_quat;
                    REG_INITIAL_SCALAR: init_reg[3] <= cfg_quat;
                    default:            ;
                endcase
            end
            if (cmd.op == OP_COMMIT)
            begin
                for (int i = 0; i < 4; i++)
                    att_reg[i] <= att_new[i];
            end
        end
    end

    // Working registers.
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_full;
        case (cmd.op)
            OP_CAPTURE:
            begin
                load_reg <= command;
                w_reg[0] <= sat32(64'(rate_x));
                w_reg[1] <= sat32(64'(rate_y));
                w_reg[2] <= sat32(64'(rate_z));
            end
            OP_INC:
            begin
                case (cmd.step)
                    3'd1:    acc_reg  <= pv;
                    3'd2,
                    3'd3:    acc_reg  <= acc_reg + pv;
                    3'd5:    wide_reg <= (WIDEW'(prod_reg) <<< 32)
                                         + (WIDEW'(1) <<< (INC_SHIFT - 1));
                    3'd6:    wide_reg <= wide_reg + $signed({34'd0, prod_reg[63:0]});
                    3'd7:    u_reg[cmd.part] <= UW'(att_reg[cmd.part]) + incv;
                    default: ;
                endcase
            end
            OP_MAG:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    mag_reg[i]  <= u_reg[i][UW-1] ? MW'(-u_reg[i]) : MW'(u_reg[i]);
                    uneg_reg[i] <= u_reg[i][UW-1];
                end
                flip_reg <= u_reg[3][UW-1] || (u_reg[3] == '0);
            end
            OP_SCALE:
            begin
                for (int i = 0; i < 4; i++)
                    mag_reg[i] <= mag_reg[i] >> 1;
            end
            OP_SQ:
            begin
                if (cmd.step == 3'd1)
                    s_reg <= prod_reg[63:0];
                else if (cmd.step != 3'd0)
                    s_reg <= s_reg + prod_reg[63:0];
            end
            OP_DINIT:
            begin
                if (a2 == s_reg)
                begin
                    quo_reg <= 64'd1;
                    rem_reg <= '0;
                end
                else
                begin
                    quo_reg <= '0;
                    rem_reg <= a2;
                end
                srem_reg <= '0;
                root_reg <= '0;
            end
            OP_DIV:
            begin
                rem_reg <= div_ge ? 64'(r2 - {1'b0, s_reg}) : r2[63:0];
                quo_reg <= {quo_reg[62:0], div_ge};
            end
            OP_SQRT:
            begin
                srem_reg <= sq_ge ? (rem2 - trial) : rem2;
                root_reg <= {root_reg[30:0], sq_ge};
                quo_reg  <= {quo_reg[61:0], 2'b00};
            end
            OP_RES:
                res_reg[cmd.part] <= (uneg_reg[cmd.part] ^ flip_reg) ? -cval : cval;
            OP_COMMIT:
            begin
                for (int i = 0; i < 4; i++)
                    out_reg[i] <= att_new[i];
                degen_reg <= !load_reg && st.s_zero;
            end
            default: ;
        endcase
    end

    assign st.is_load = load_reg;
    assign st.s_zero  = (s_reg == '0);
    assign st.fits    = (mag_reg[0][MW-1:31] == '0) && (mag_reg[1][MW-1:31] == '0) &&
                        (mag_reg[2][MW-1:31] == '0) && (mag_reg[3][MW-1:31] == '0);

    assign att_x      = QUAT_WIDTH'(out_reg[0]);
    assign att_y      = QUAT_WIDTH'(out_reg[1]);
    assign att_z      = QUAT_WIDTH'(out_reg[2]);
    assign att_scalar = QUAT_WIDTH'(out_reg[3]);
    assign degenerate = degen_reg;

endmodule

// ===== test/attitude_quaternion_integrator_core_test.sv =====
// Self-checking testbench of the attitude quaternion integrator core.
`timescale 1ns / 1ps

module attitude_quaternion_integrator_core_test
    import aqi_pkg::*;
;

    typedef struct {
        logic signed [31:0] part[4];
        logic               degenerate;
    } attitude_word_t;

    // Predicts the attitude after each accepted word and checks the returned words.
    class attitude_scoreboard;
        logic [31:0]    step_time;
        longint         init_att[4];
        longint         att[4];
        attitude_word_t pending[$];
        int             errors;

        function new();
            step_time = STEP_TIME_RESET;
            init_att = '{0, 0, 0, longint'(ONE_Q30)};
            att = init_att;
            errors = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] v);
            case (idx)
                REG_STEP_TIME:      step_time = v;
                REG_INITIAL_X:      init_att[0] = longint'($signed(v));
                REG_INITIAL_Y:      init_att[1] = longint'($signed(v));
                REG_INITIAL_Z:      init_att[2] = longint'($signed(v));
                REG_INITIAL_SCALAR: init_att[3] = longint'($signed(v));
                default: ;
            endcase
        endfunction

        // Half of the rate term times step time, rounded half up to Q.30.
        function longint rate_increment(longint p0, longint p1, longint p2);
            logic signed [127:0] acc;
            acc = p0;
            acc = acc + p1;
            acc = acc + p2;
            acc = acc * $signed({96'd0, step_time});
            acc = acc + (128'sd1 <<< 48);
            acc = acc >>> 49;
            return acc[63:0];
        endfunction

        // Nearest integer to a * 2^30 / sqrt(s), found bit by bit.
        function longint unit_magnitude(longint a, logic [127:0] s);
            logic [127:0] rhs;
            logic [127:0] lhs;
            logic [127:0] t;
            longint       r;
            longint       c;
            rhs = a;
            rhs = (rhs * rhs) << 62;
            r = 0;
            for (int b = 30; b >= 0; b--)
            begin
                c = r | (64'd1 << b);
                t = 2 * c - 1;
                lhs = t * t * s;
                if (lhs <= rhs)
                    r = c;
            end
            return r;
        endfunction

        function void note_input(logic cmd, logic signed [31:0] rx, logic signed [31:0] ry,
                                 logic signed [31:0] rz);
            attitude_word_t w;
            longint         wx, wy, wz, ax, ay, az, as;
            longint         u[4];
            longint         mag[4];
            logic [127:0]   s;
            int             sh;
            logic           flip;
            logic           neg;
            longint         r;
            w.degenerate = 1'b0;
            if (cmd)
                att = init_att;
            else
            begin
                wx = rx; wy = ry; wz = rz;
                ax = att[0]; ay = att[1]; az = att[2]; as = att[3];
                u[0] = ax + rate_increment(as * wx, -(az * wy), ay * wz);
                u[1] = ay + rate_increment(az * wx, as * wy, -(ax * wz));
                u[2] = az + rate_increment(-(ay * wx), ax * wy, as * wz);
                u[3] = as + rate_increment(-(ax * wx), -(ay * wy), -(az * wz));
                for (int i = 0; i < 4; i++)
                    mag[i] = (u[i] < 0) ? -u[i] : u[i];
                // block scaling: common right shift until every part fits 31 bits
                sh = 0;
                for (int i = 0; i < 4; i++)
                    while ((mag[i] >> sh) >= (64'd1 << 31))
                        sh++;
                s = 0;
                for (int i = 0; i < 4; i++)
                begin
                    mag[i] = mag[i] >> sh;
                    s = s + 128'(mag[i]) * 128'(mag[i]);
                end
                if (s == 0)
                    w.degenerate = 1'b1;
                else
                begin
                    flip = !(u[3] > 0);
                    for (int i = 0; i < 4; i++)
                    begin
                        r = unit_magnitude(mag[i], s);
                        neg = (u[i] < 0) != flip;
                        att[i] = neg ? -r : r;
                    end
                end
            end
            for (int i = 0; i < 4; i++)
                w.part[i] = att[i][31:0];
            pending.push_back(w);
        endfunction

        function void check(attitude_word_t got);
            attitude_word_t want;
            string          names[4];
            names = '{"att_x", "att_y", "att_z", "att_scalar"};
            if (pending.size() == 0)
            begin
                $error("result word with no expectation waiting");
                errors++;
                return;
            end
            want = pending.pop_front();
            for (int i = 0; i < 4; i++)
                if (got.part[i] !== want.part[i])
                begin
                    $error("%s: expected %0d, got %0d", names[i], want.part[i], got.part[i]);
                    errors++;
                end
            if (got.degenerate !== want.degenerate)
            begin
                $error("degenerate: expected %0d, got %0d", want.degenerate, got.degenerate);
                errors++;
            end
        endfunction
    endclass

    localparam int STALL_LIMIT = 40000;   // idle cycles before the watchdog fires
    localparam int LONG_HOLD   = 3000;    // receiver hold-off, well beyond one propagate

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [31:0]          cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    logic                 command;
    logic signed [31:0]   rate_x, rate_y, rate_z;
    logic                 out_valid;
    logic                 out_stall;
    logic signed [31:0]   att_x, att_y, att_z, att_scalar;
    logic                 degenerate;

    attitude_scoreboard sb;
    int                 results_seen;
    int                 idle_cycles;
    bit                 hold_done;

    attitude_quaternion_integrator_core DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .command    (command),
        .rate_x     (rate_x),
        .rate_y     (rate_y),
        .rate_z     (rate_z),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .att_x      (att_x),
        .att_y      (att_y),
        .att_z      (att_z),
        .att_scalar (att_scalar),
        .degenerate (degenerate)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Write one register on the plain write port; call only while idle.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] v);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = v;
        @(posedge clk);
        sb.write_reg(idx, v);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // Offer one word, hold it until taken, then drop valid for the given gap, if any.
    task automatic send_word(logic cmd, logic [31:0] rx, logic [31:0] ry, logic [31:0] rz,
                             int gap);
        @(negedge clk);
        in_valid = 1'b1;
        command = cmd;
        rate_x = rx;
        rate_y = ry;
        rate_z = rz;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_input(cmd, rx, ry, rz);
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic finish_word();
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    // Drain every expected word, then let the block settle before a register write.
    task automatic drain();
        finish_word();
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic load_initial(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                logic [31:0] s);
        drain();
        write_reg(REG_INITIAL_X, x);
        write_reg(REG_INITIAL_Y, y);
        write_reg(REG_INITIAL_Z, z);
        write_reg(REG_INITIAL_SCALAR, s);
        send_word(1'b1, $urandom, $urandom, $urandom, 1);
    endtask

    function automatic logic [31:0] small_rate();
        return $urandom_range(0, 32'h0400_0000) - 32'h0200_0000;
    endfunction

    // Random burst: mostly plausible gyro rates, some full-range noise and loads.
    task automatic random_burst(int count);
        int burst;
        int gap;
        burst = 0;
        for (int n = 0; n < count; n++)
        begin
            if (burst == 0)
            begin
                burst = $urandom_range(1, 12);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 600);
            end
            burst--;
            case ($urandom_range(0, 9))
                0:       send_word(1'b1, $urandom, $urandom, $urandom, burst ? 0 : gap);
                1, 2:    send_word(1'b0, $urandom, $urandom, $urandom, burst ? 0 : gap);
                default: send_word(1'b0, small_rate(), small_rate(), small_rate(),
                                   burst ? 0 : gap);
            endcase
        end
    endtask

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_STEP_TIME;
        cfg_data = '0;
        in_valid = 1'b0;
        command = 1'b0;
        rate_x = '0;
        rate_y = '0;
        rate_z = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: reset attitude, zero and extreme rates.
        send_word(1'b0, 32'd0, 32'd0, 32'd0, 0);
        send_word(1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
        send_word(1'b0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);
        send_word(1'b0, 32'h0100_0000, 32'h8000_0000, 32'h7FFF_FFFF, 0);
        send_word(1'b1, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 0);
        // Zero norm: all-zero initial attitude, so the state is held.
        load_initial(32'd0, 32'd0, 32'd0, 32'd0);
        send_word(1'b0, 32'h0123_4567, 32'h89AB_CDEF, 32'h7FFF_FFFF, 0);
        // Extreme attitude parts force block scaling; negative scalar flips signs.
        load_initial(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        send_word(1'b0, 32'd0, 32'd0, 32'd0, 0);
        load_initial(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_word(1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 0);
        // Scalar exactly zero also counts as not positive.
        load_initial(32'h4000_0000, 32'd0, 32'd0, 32'd0);
        send_word(1'b0, 32'd0, 32'd0, 32'd0, 0);
        drain();
        write_reg(REG_STEP_TIME, 32'd0);
        send_word(1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0);
        drain();
        write_reg(REG_STEP_TIME, 32'hFFFF_FFFF);
        send_word(1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 0);
        send_word(1'b0, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0, 0);

        // Random phases, each under its own step time and initial attitude.
        drain();
        write_reg(REG_STEP_TIME, 32'd167772);          // about 10 ms
        load_initial(32'd0, 32'd0, 32'd0, ONE_Q30);
        random_burst(100);
        drain();
        write_reg(REG_STEP_TIME, STEP_TIME_RESET);
        load_initial($urandom, $urandom, $urandom, $urandom);
        random_burst(100);
        drain();
        write_reg(REG_STEP_TIME, $urandom);
        load_initial($urandom, $urandom, $urandom, $urandom);
        random_burst(90);
        drain();
        write_reg(REG_STEP_TIME, 32'd1677);            // about 100 us
        load_initial(32'h2000_0000, 32'hE000_0000, 32'h2000_0000, 32'h2000_0000);
        random_burst(90);

        drain();
        repeat (500) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Receiver stall pattern, with one long hold-off so the block backs up.
    initial
    begin
        int hold;
        out_stall = 1'b0;
        hold = 0;
        hold_done = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!hold_done && results_seen == 40)
            begin
                hold = LONG_HOLD;
                hold_done = 1'b1;
            end
            if (hold > 0)
            begin
                hold--;
                out_stall = 1'b1;
            end
            else if ((results_seen / 16) % 3 == 0)
                out_stall = 1'b0;
            else
                out_stall = ($urandom_range(0, 2) == 0);
        end
    end

    // Sample results and run the watchdog at the rising edge.
    initial
    begin
        attitude_word_t got;
        results_seen = 0;
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                got.part = '{att_x, att_y, att_z, att_scalar};
                got.degenerate = degenerate;
                sb.check(got);
                results_seen++;
                idle_cycles = 0;
            end
            else if (in_valid && !in_stall)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

endmodule
